>>> design/bgc_pkg.sv
package bgc_pkg;

   // Gesture state, also reported as current_gesture
   typedef enum logic [2:0] {
      GS_RELEASED = 3'd0,
      GS_PRESSED  = 3'd1,
      GS_HELD     = 3'd2,
      GS_DPRESSED = 3'd3,
      GS_DHELD    = 3'd4
   } gesture_type;

   // Event code reported with every item
   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_PRESS   = 3'd1,
      EV_DPRESS  = 3'd2,
      EV_HOLD    = 3'd3,
      EV_DHOLD   = 3'd4,
      EV_RELEASE = 3'd5
   } event_type;

   // Register word indexes (byte address = 4 * index)
   localparam logic [1:0] REG_HOLD_TIMEOUT = 2'd0;
   localparam logic [1:0] REG_DP_WINDOW    = 2'd1;
   localparam logic [1:0] REG_BUTTON_ID    = 2'd2;

   localparam logic [15:0] HOLD_TIMEOUT_RESET = 16'd1000;
   localparam logic [15:0] DP_WINDOW_RESET    = 16'd500;
   localparam logic [7:0]  BUTTON_ID_RESET    = 8'd0;

endpackage

>>> design/button_gesture_classifier_core.sv
// Each accepted req_ item is registered as its rsp_ item in the output register.
// One item per cycle when not stalled; gesture state and counters update on accept.
// req_tready stays high while the output register is empty or being taken.
// Synchronous active-high reset: state released, press count all ones, timer disarmed,
// registers back to hold timeout 1000, double-press window 500, button id 0.
module button_gesture_classifier_core
   import bgc_pkg::*;
#(
   parameter int TIME_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input item
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] button_level, [7:1] zero
   // result item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [2:0] gesture_event, [10:3] event_button,
                                    // [13:11] current_gesture, [15:14] zero
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CW = (TIME_WIDTH + 1 > 17) ? TIME_WIDTH + 1 : 17;
   localparam logic [TIME_WIDTH:0]   TSP_MAX  = '1;
   localparam logic [TIME_WIDTH-1:0] HOLD_MAX = '1;

   // Configuration registers
   logic [15:0] hold_timeout_ff;
   logic [15:0] dp_window_ff;
   logic [7:0]  button_id_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_timeout_ff <= HOLD_TIMEOUT_RESET;
         dp_window_ff    <= DP_WINDOW_RESET;
         button_id_ff    <= BUTTON_ID_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_HOLD_TIMEOUT: hold_timeout_ff <= csr_pwdata[15:0];
            REG_DP_WINDOW:    dp_window_ff    <= csr_pwdata[15:0];
            REG_BUTTON_ID:    button_id_ff    <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_HOLD_TIMEOUT: csr_prdata = {16'd0, hold_timeout_ff};
         REG_DP_WINDOW:    csr_prdata = {16'd0, dp_window_ff};
         REG_BUTTON_ID:    csr_prdata = {24'd0, button_id_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   // Gesture state and timers
   gesture_type             state_ff, state_in;
   logic [TIME_WIDTH:0]     tsp_ff, tsp_in, tsp_adv;
   logic [TIME_WIDTH-1:0]   hold_ff, hold_in, hold_adv;
   logic                    armed_ff, armed_in;
   logic                    level, dbl_hit, hold_fire, accept;
   event_type               event_in;

   logic                    rsp_valid_ff;
   event_type               rsp_event_ff;
   logic [7:0]              rsp_button_ff;
   gesture_type             rsp_state_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign level      = req_tdata[0];

   // Advance the counters and evaluate the window and timeout compares
   always_comb begin
      tsp_adv   = (tsp_ff == TSP_MAX) ? tsp_ff : tsp_ff + 1'b1;
      hold_adv  = (hold_ff == HOLD_MAX) ? hold_ff : hold_ff + 1'b1;
      dbl_hit   = (tsp_adv != TSP_MAX) && (CW'(tsp_adv) <= CW'(dp_window_ff));
      hold_fire = armed_ff && (CW'(hold_adv) >= CW'(hold_timeout_ff));
   end

   // Next gesture state
   always_comb begin
      state_in = state_ff;
      if (state_ff == GS_RELEASED) begin
         if (level) state_in = dbl_hit ? GS_DPRESSED : GS_PRESSED;
      end else if (!level) begin
         state_in = GS_RELEASED;
      end else if (hold_fire) begin
         if (state_ff == GS_PRESSED)       state_in = GS_HELD;
         else if (state_ff == GS_DPRESSED) state_in = GS_DHELD;
      end
   end

   // Event code for this tick
   always_comb begin
      event_in = EV_NONE;
      if (state_ff == GS_RELEASED) begin
         if (level) event_in = dbl_hit ? EV_DPRESS : EV_PRESS;
      end else if (!level) begin
         event_in = EV_RELEASE;
      end else if (hold_fire) begin
         if (state_ff == GS_PRESSED)       event_in = EV_HOLD;
         else if (state_ff == GS_DPRESSED) event_in = EV_DHOLD;
      end
   end

   // Press counter and hold timer updates
   always_comb begin
      tsp_in   = tsp_adv;
      hold_in  = hold_ff;
      armed_in = armed_ff;
      if (state_ff == GS_RELEASED) begin
         if (level) begin
            tsp_in   = dbl_hit ? TSP_MAX : '0;
            hold_in  = '0;
            armed_in = 1'b1;
         end
      end else if (!level) begin
         armed_in = 1'b0;
      end else if (armed_ff) begin
         hold_in = hold_adv;
         if (hold_fire) armed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GS_RELEASED;
         tsp_ff   <= TSP_MAX;
         hold_ff  <= '0;
         armed_ff <= 1'b0;
      end else if (accept) begin
         state_ff <= state_in;
         tsp_ff   <= tsp_in;
         hold_ff  <= hold_in;
         armed_ff <= armed_in;
      end
   end

   // Output register: load on accept, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_event_ff  <= event_in;
         rsp_button_ff <= button_id_ff;
         rsp_state_ff  <= state_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_state_ff, rsp_button_ff, rsp_event_ff};

   // Checks
   a_held_disarmed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == GS_HELD || state_ff == GS_DHELD) |-> !armed_ff)
      else $error("timer armed in a held state");

   a_press_arms: assert property (@(posedge clock) disable iff (reset)
      (accept && state_ff == GS_RELEASED && level) |=> (armed_ff && hold_ff == '0))
      else $error("press did not arm the hold timer");

   a_dpress_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && event_in == EV_DPRESS) |=> (tsp_ff == TSP_MAX))
      else $error("double press left a pending press");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_valid_ff)
      else $error("input stalled with empty output register");

   a_release_state: assert property (@(posedge clock) disable iff (reset)
      (accept && event_in == EV_RELEASE) |=> (state_ff == GS_RELEASED && !armed_ff))
      else $error("release did not return to released");

endmodule

>>> verif/tb_top.sv
module tb_top;
   import bgc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int            CYCLE_LIMIT  = 1000000;
   localparam int            PHASES       = 8;
   localparam int            PHASE_ITEMS  = 220;
   localparam logic [16:0]   COUNT_SAT    = 17'h1FFFF;
   localparam logic [15:0]   HOLD_SAT     = 16'hFFFF;

   // result fields in rsp_tdata order, lowest field last
   typedef struct packed {
      gesture_type gs;
      logic [7:0]  btn;
      event_type   ev;
   } gesture_result_type;

   // typed expectation carried with a directed item
   typedef struct packed {
      logic        known;
      event_type   ev;
      gesture_type gs;
   } tick_note_type;

   typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      logic          level;
      tick_note_type note;
      logic [1:0]    reg_idx;
      logic [15:0]   value;
   } plan_row_type;

   localparam tick_note_type NO_NOTE = '{1'b0, EV_NONE, GS_RELEASED};

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;   // [0] button_level, [7:1] zero
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;          // [2:0] gesture_event, [10:3] event_button,
                                    // [13:11] current_gesture, [15:14] zero
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // register copies used by the gesture predictor
   logic [15:0] cfg_hold_timeout = HOLD_TIMEOUT_RESET;
   logic [15:0] cfg_dp_window    = DP_WINDOW_RESET;
   logic [7:0]  cfg_button_id    = BUTTON_ID_RESET;

   // predictor state
   gesture_type gs_q        = GS_RELEASED;
   logic [16:0] since_press = COUNT_SAT;
   logic [15:0] hold_cnt    = '0;
   logic        hold_on     = 1'b0;

   gesture_result_type pending_gestures [$];
   tick_note_type      tick_notes [$];
   int                 mismatch_count = 0;
   int                 cycle_count    = 0;
   int                 send_gap_pct   = 0;
   int                 stall_pct      = 0;

   plan_row_type plan [0:27];

   int ph_timeout [PHASES] = '{1, 5, 65535, 0, -1, -1, 3, -1};
   int ph_window  [PHASES] = '{0, 8, 65535, 2, -1, -1, 65535, 0};
   int ph_button  [PHASES] = '{0, 'h5A, 'hFF, 'hA5, -1, -1, -1, -1};
   int ph_gap     [PHASES] = '{0, 88, 0, 0, 34, 88, 0, 34};
   int ph_stall   [PHASES] = '{0, 0, 0, 88, 34, 0, 88, 34};

   button_gesture_classifier_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // advance the gesture state by one tick and return the event it causes
   function automatic gesture_result_type classify_tick(input logic level);
      gesture_result_type res;
      res.ev = EV_NONE;
      if (since_press != COUNT_SAT) since_press = since_press + 17'd1;
      if (gs_q == GS_RELEASED) begin
         if (level) begin
            if (since_press != COUNT_SAT && since_press <= {1'b0, cfg_dp_window}) begin
               gs_q        = GS_DPRESSED;
               res.ev      = EV_DPRESS;
               since_press = COUNT_SAT;
            end else begin
               gs_q        = GS_PRESSED;
               res.ev      = EV_PRESS;
               since_press = '0;
            end
            hold_cnt = '0;
            hold_on  = 1'b1;
         end
      end else if (!level) begin
         gs_q    = GS_RELEASED;
         res.ev  = EV_RELEASE;
         hold_on = 1'b0;
      end else if (hold_on) begin
         if (hold_cnt != HOLD_SAT) hold_cnt = hold_cnt + 16'd1;
         if (hold_cnt >= cfg_hold_timeout) begin
            hold_on = 1'b0;
            if (gs_q == GS_PRESSED) begin
               gs_q   = GS_HELD;
               res.ev = EV_HOLD;
            end else if (gs_q == GS_DPRESSED) begin
               gs_q   = GS_DHELD;
               res.ev = EV_DHOLD;
            end
         end
      end
      res.btn = cfg_button_id;
      res.gs  = gs_q;
      return res;
   endfunction

   // randomize the result side handshake
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // check results first, then predict for the item accepted at this edge
   always @(posedge clock) begin
      gesture_result_type got;
      gesture_result_type want;
      tick_note_type      note;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[13:0];
            if (pending_gestures.size() == 0) begin
               $display("%0t: unexpected item: expected none, actual ev=%0d btn=%0h gs=%0d",
                        $time, got.ev, got.btn, got.gs);
               mismatch_count++;
            end else begin
               want = pending_gestures.pop_front();
               if (got.ev !== want.ev || got.btn !== want.btn || got.gs !== want.gs) begin
                  $display("%0t: mismatch: expected ev=%0d btn=%0h gs=%0d,",
                           $time, want.ev, want.btn, want.gs,
                           " actual ev=%0d btn=%0h gs=%0d",
                           got.ev, got.btn, got.gs);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            note = (tick_notes.size() != 0) ? tick_notes.pop_front() : NO_NOTE;
            want = classify_tick(req_tdata[0]);
            if (note.known) begin
               want.ev = note.ev;
               want.gs = note.gs;
            end
            pending_gestures.push_back(want);
         end
      end
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // present one tick, with random idle cycles ahead of it
   task automatic send_tick(input logic level, input tick_note_type note);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, level};
      tick_notes.push_back(note);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // hold off until every expected item has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_gestures.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_HOLD_TIMEOUT: cfg_hold_timeout = value[15:0];
         REG_DP_WINDOW:    cfg_dp_window    = value[15:0];
         REG_BUTTON_ID:    cfg_button_id    = value[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // mostly clean press/release runs sized around the timeout and window, some noise
   task automatic run_gestures(input int n_items);
      int sent;
      int len;
      int hold_span;
      int win_span;
      hold_span = (cfg_hold_timeout > 40) ? 40 : int'(cfg_hold_timeout);
      win_span  = (cfg_dp_window > 40) ? 40 : int'(cfg_dp_window);
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 85) begin
            len = $urandom_range(1, hold_span * 2 + 2);
            repeat (len) send_tick(1'b1, NO_NOTE);
            sent += len;
            len = $urandom_range(1, win_span + 3);
            repeat (len) send_tick(1'b0, NO_NOTE);
            sent += len;
         end else begin
            len = $urandom_range(1, 4);
            repeat (len) send_tick(1'($urandom_range(1)), NO_NOTE);
            sent += len;
         end
      end
   endtask

   initial begin
      plan = '{
         // reset settings: plain press, double press, no recent press
         '{ROW_TICK, 1'b0, '{1'b1, EV_NONE, GS_RELEASED}, REG_HOLD_TIMEOUT, 16'd0},
         '{ROW_TICK, 1'b1, '{1'b1, EV_PRESS, GS_PRESSED}, REG_HOLD_TIMEOUT, 16'd0},
         '{ROW_TICK, 1'b1, '{1'b1, EV_NONE, GS_PRESSED}, REG_HOLD_TIMEOUT, 16'd0},
         '{ROW_TICK, 1'b0, '{1'b1, EV_RELEASE, GS_RELEASED}, REG_HOLD_TIMEOUT, 16'd0},
         '{ROW_TICK, 1'b1, '{1'b1, EV_DPRESS, GS_DPRESSED}, REG_HOLD_TIMEOUT, 16'd0},
         '{ROW_TICK, 1'b0, '{1'b1, EV_RELEASE, GS_RELEASED}, REG_HOLD_TIMEOUT, 16'd0},
         '{ROW_TICK, 1'b1, '{1'b1, EV_PRESS, GS_PRESSED}, REG_HOLD_TIMEOUT, 16'd0},
         '{ROW_TICK, 1'b0, '{1'b1, EV_RELEASE, GS_RELEASED}, REG_HOLD_TIMEOUT, 16'd0},
         // shortest timeout, zero window, all-ones button
         '{ROW_WRITE, 1'b0, NO_NOTE, REG_HOLD_TIMEOUT, 16'd1},
         '{ROW_WRITE, 1'b0, NO_NOTE, REG_DP_WINDOW, 16'd0},
         '{ROW_WRITE, 1'b0, NO_NOTE, REG_BUTTON_ID, 16'h00FF},
         '{ROW_TICK, 1'b1, '{1'b1, EV_PRESS, GS_PRESSED}, REG_HOLD_TIMEOUT, 16'd0},
         '{ROW_TICK, 1'b1, '{1'b1, EV_HOLD, GS_HELD}, REG_HOLD_TIMEOUT, 16'd0},
         '{ROW_TICK, 1'b1, '{1'b1, EV_NONE, GS_HELD}, REG_HOLD_TIMEOUT, 16'd0},
         '{ROW_TICK, 1'b0, '{1'b1, EV_RELEASE, GS_RELEASED}, REG_HOLD_TIMEOUT, 16'd0},
         '{ROW_TICK, 1'b1, '{1'b1, EV_PRESS, GS_PRESSED}, REG_HOLD_TIMEOUT, 16'd0},
         '{ROW_TICK, 1'b0, '{1'b1, EV_RELEASE, GS_RELEASED}, REG_HOLD_TIMEOUT, 16'd0},
         // widest window, zero timeout: hold on the first tick after a double press
         '{ROW_WRITE, 1'b0, NO_NOTE, REG_DP_WINDOW, 16'hFFFF},
         '{ROW_WRITE, 1'b0, NO_NOTE, REG_HOLD_TIMEOUT, 16'd0},
         '{ROW_TICK, 1'b1, '{1'b1, EV_DPRESS, GS_DPRESSED}, REG_HOLD_TIMEOUT, 16'd0},
         '{ROW_TICK, 1'b1, '{1'b1, EV_DHOLD, GS_DHELD}, REG_HOLD_TIMEOUT, 16'd0},
         '{ROW_TICK, 1'b1, '{1'b1, EV_NONE, GS_DHELD}, REG_HOLD_TIMEOUT, 16'd0},
         '{ROW_TICK, 1'b0, '{1'b1, EV_RELEASE, GS_RELEASED}, REG_HOLD_TIMEOUT, 16'd0},
         // double press clears the pending press; release wins over hold
         '{ROW_WRITE, 1'b0, NO_NOTE, REG_BUTTON_ID, 16'h0000},
         '{ROW_TICK, 1'b1, '{1'b1, EV_PRESS, GS_PRESSED}, REG_HOLD_TIMEOUT, 16'd0},
         '{ROW_TICK, 1'b0, '{1'b1, EV_RELEASE, GS_RELEASED}, REG_HOLD_TIMEOUT, 16'd0},
         '{ROW_TICK, 1'b1, '{1'b1, EV_DPRESS, GS_DPRESSED}, REG_HOLD_TIMEOUT, 16'd0},
         '{ROW_TICK, 1'b0, '{1'b1, EV_RELEASE, GS_RELEASED}, REG_HOLD_TIMEOUT, 16'd0}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed items
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) begin
            drain_results();
            csr_write(plan[i].reg_idx, {16'd0, plan[i].value});
         end else begin
            send_tick(plan[i].level, plan[i].note);
         end
      end

      // random phases, each with its own settings and idle pattern
      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         send_gap_pct = ph_gap[p];
         stall_pct    = ph_stall[p];
         csr_write(REG_HOLD_TIMEOUT,
                   (ph_timeout[p] < 0) ? $urandom_range(1, 30) : ph_timeout[p]);
         csr_write(REG_DP_WINDOW,
                   (ph_window[p] < 0) ? $urandom_range(0, 30) : ph_window[p]);
         csr_write(REG_BUTTON_ID,
                   (ph_button[p] < 0) ? $urandom_range(0, 255) : ph_button[p]);
         run_gestures(PHASE_ITEMS);
      end

      drain_results();
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> sim.f
design/bgc_pkg.sv
design/button_gesture_classifier_core.sv
verif/tb_top.sv
